[rtl/assert_macros.svh]
// Assertion helpers included by the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The property must hold at every clock edge, including reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/pat_pkg.sv]
`default_nettype none
package pat_pkg;

    localparam int unsigned IMP_W   = 15;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned SLICE_W = 16;

    localparam logic [IMP_W-1:0] IMP_MAX = 15'h7FFF;

    typedef enum logic [3:0] {
        OP_ALLOC   = 4'd0,
        OP_THINK   = 4'd1,
        OP_INFER   = 4'd2,
        OP_LEARN   = 4'd3,
        OP_UPDATE  = 4'd4,
        OP_DECAY   = 4'd5,
        OP_STATS   = 4'd6,
        OP_FINDMAX = 4'd7,
        OP_SPREAD  = 4'd8,
        OP_BOOST   = 4'd9,
        OP_SLEEP   = 4'd10,
        OP_RESUME  = 4'd11,
        OP_QUERY   = 4'd12
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_THINKING  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REASONING = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WAITING   = 3'd4;

    localparam logic [1:0] CFG_SLICE_LONG  = 2'd0;
    localparam logic [1:0] CFG_SLICE_MID   = 2'd1;
    localparam logic [1:0] CFG_SLICE_SHORT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,      // read address presented
        S_WAIT,    // read data registering
        S_EXEC,    // compute and write single entry
        S_RD2,     // spread target read
        S_WAIT2,
        S_EXEC2,
        S_SWEEP,   // walk entries
        S_SWEND,
        S_OUT
    } state_t;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;       // capture input item
        logic rd_src;     // read at entry
        logic rd_tgt;     // read at target
        logic exec;       // apply single-entry op
        logic exec2;      // apply spread target write
        logic sw_start;   // reset sweep pointer and sums
        logic sw_step;    // issue read at sweep pointer
        logic out_load;   // register result
    } pat_cmd_t;

    // Datapath status to the controller.
    typedef struct packed {
        logic sw_last;    // last sweep read issued
        logic sw_empty;   // nothing to sweep
        logic need_read;  // op touches an allocated entry
        logic need_tgt;   // spread will write target
        logic is_sweep;
    } pat_sts_t;

endpackage
`default_nettype wire

[rtl/process_attention_table_unit.sv]
`default_nettype none
// Table of process attention records. One result per input transfer.
// Operations on a live entry make a registered read of the entry memory,
// then one write (query only reads); spread, when the source holds the
// amount, takes a second read and write for its target. Decay, statistics
// and find-max walk every allocated entry through the single memory read
// port. The user writes slice registers through the cfg channel only
// while the block is idle; the block itself does not enforce this.
module process_attention_table_unit #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode[3:0], entry[9:4], target_entry[15:10], delta_short[31:16],
    // delta_long[47:32], amount[63:48]
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], entry_index[7:2], found[8], priority_res[24:9],
    // time_slice[40:25], total_inferences[72:41], total_cycles[104:73],
    // entry_total[111:105]
    output logic [111:0]     m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import pat_pkg::*;

    logic [SLICE_W-1:0] slice_long_reg, slice_mid_reg, slice_short_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_long_reg  <= 16'd20;
            slice_mid_reg   <= 16'd10;
            slice_short_reg <= 16'd5;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SLICE_LONG:  slice_long_reg  <= cfg_data;
                CFG_SLICE_MID:   slice_mid_reg   <= cfg_data;
                CFG_SLICE_SHORT: slice_short_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pat_cmd_t cmd;
    pat_sts_t sts;
    logic [1:0]  o_status;
    logic [5:0]  o_index;
    logic        o_found;
    logic [15:0] o_prio, o_slice;
    logic [31:0] o_tinf, o_tcyc;
    logic [6:0]  o_total;

    pat_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .sts(sts), .cmd(cmd)
    );

    pat_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_opcode(s_tdata[3:0]), .in_entry(s_tdata[9:4]),
        .in_target(s_tdata[15:10]), .in_ds(s_tdata[31:16]),
        .in_dl(s_tdata[47:32]), .in_amt(s_tdata[63:48]),
        .slice_long(slice_long_reg), .slice_mid(slice_mid_reg),
        .slice_short(slice_short_reg),
        .cmd(cmd), .sts(sts),
        .o_status(o_status), .o_index(o_index), .o_found(o_found),
        .o_prio(o_prio), .o_slice(o_slice), .o_tinf(o_tinf),
        .o_tcyc(o_tcyc), .o_total(o_total)
    );

    assign m_tdata = {o_total, o_tcyc, o_tinf, o_slice, o_prio, o_found,
                      o_index, o_status};
endmodule
`default_nettype wire

[rtl/pat_ctrl.sv]
`default_nettype none
module pat_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  wire pat_pkg::pat_sts_t sts,
    output pat_pkg::pat_cmd_t    cmd
);
    import pat_pkg::*;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    // State and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign s_tready = (state_reg == S_IDLE) && !mvalid_reg;

    // Next state and commands.
    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                if (sts.is_sweep) begin
                    cmd.sw_start = 1'b1;
                    state_next   = sts.sw_empty ? S_OUT : S_SWEEP;
                end else if (sts.need_read) begin
                    cmd.rd_src = 1'b1;
                    state_next = S_WAIT;
                end else begin
                    state_next = S_EXEC;
                end
            end
            S_WAIT:  state_next = S_EXEC;
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.need_tgt ? S_RD2 : S_OUT;
            end
            S_RD2: begin
                cmd.rd_tgt = 1'b1;
                state_next = S_WAIT2;
            end
            S_WAIT2: state_next = S_EXEC2;
            S_EXEC2: begin
                cmd.exec2  = 1'b1;
                state_next = S_OUT;
            end
            S_SWEEP: begin
                cmd.sw_step = 1'b1;
                if (sts.sw_last) state_next = S_SWEND;
            end
            S_SWEND: begin
                cmd.sw_step = 1'b0;
                state_next  = S_OUT;
            end
            S_OUT: begin
                cmd.out_load = 1'b1;
                mvalid_next  = 1'b1;
                state_next   = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[rtl/pat_datapath.sv]
`default_nettype none
`include "assert_macros.svh"
module pat_datapath #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [3:0]               in_opcode,
    input  wire logic [5:0]               in_entry,
    input  wire logic [5:0]               in_target,
    input  wire logic signed [15:0]       in_ds,
    input  wire logic signed [15:0]       in_dl,
    input  wire logic signed [15:0]       in_amt,
    input  wire logic [pat_pkg::SLICE_W-1:0] slice_long,
    input  wire logic [pat_pkg::SLICE_W-1:0] slice_mid,
    input  wire logic [pat_pkg::SLICE_W-1:0] slice_short,
    input  wire pat_pkg::pat_cmd_t        cmd,
    output pat_pkg::pat_sts_t             sts,
    output logic [1:0]                    o_status,
    output logic [5:0]                    o_index,
    output logic                          o_found,
    output logic [15:0]                   o_prio,
    output logic [15:0]                   o_slice,
    output logic [31:0]                   o_tinf,
    output logic [31:0]                   o_tcyc,
    output logic [6:0]                    o_total
);
    import pat_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned UW = $clog2(TABLE_DEPTH + 1);
    localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);

    typedef struct packed {
        logic [IMP_W-1:0]  si;
        logic [IMP_W-1:0]  li;
        logic [CNT_W-1:0]  inf;
        logic [CNT_W-1:0]  cyc;
        logic [MODE_W-1:0] md;
    } rec_t;

    // Entry memory: one write port, one registered read port.
    rec_t mem [TABLE_DEPTH];
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic          re;
    rec_t          wdata, rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata_reg <= mem[raddr];
    end

    // Captured item.
    logic [3:0]        op_reg;
    logic [5:0]        e_reg, t_reg;
    logic signed [15:0] ds_reg, dl_reg, amt_reg;
    logic [UW-1:0]     used_reg, used_next;
    logic [AW-1:0]     e_addr, t_addr;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_opcode;
            e_reg   <= in_entry;
            t_reg   <= in_target;
            ds_reg  <= in_ds;
            dl_reg  <= in_dl;
            amt_reg <= in_amt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) used_reg <= '0;
        else          used_reg <= used_next;
    end

    assign e_addr = AW'(e_reg);
    assign t_addr = AW'(t_reg);

    logic e_live, t_live, full;
    assign e_live = 32'(e_reg) < 32'(used_reg);
    assign t_live = 32'(t_reg) < 32'(used_reg);
    assign full   = (used_reg >= DEPTH_U);

    logic is_single;
    always_comb begin
        case (op_reg)
            OP_THINK, OP_INFER, OP_LEARN, OP_UPDATE, OP_BOOST, OP_SLEEP,
            OP_RESUME, OP_QUERY: is_single = e_live;
            OP_SPREAD:           is_single = e_live && t_live;
            default:             is_single = 1'b0;
        endcase
    end

    assign sts.is_sweep  = (op_reg == OP_DECAY) || (op_reg == OP_STATS) ||
                           (op_reg == OP_FINDMAX);
    assign sts.need_read = is_single;
    assign sts.sw_empty  = (used_reg == '0);

    // Clamp of a signed sum to the importance range.
    function automatic logic [IMP_W-1:0] clampi(input logic signed [17:0] v);
        logic [IMP_W-1:0] r;
        if (v < 0)                          r = '0;
        else if (v > 18'sd32767)            r = IMP_MAX;
        else                                r = v[IMP_W-1:0];
        return r;
    endfunction

    // Signed divide by ten, truncating toward zero, via reciprocal multiply.
    logic [15:0] amt_mag;
    logic [31:0] q_prod;
    logic [15:0] q_mag;
    logic signed [17:0] amt_div;
    assign amt_mag = amt_reg[15] ? 16'(-amt_reg) : amt_reg;
    assign q_prod  = 32'(amt_mag) * 32'd52429;
    assign q_mag   = q_prod[34-3 -: 16] >> 3;
    assign amt_div = amt_reg[15] ? -$signed({2'b0, q_mag}) : $signed({2'b0, q_mag});

    // Sleep: floor(s*9/10) is s minus ceil(s/10), and ceil(s/10) is
    // floor((s+9)/10), which the reciprocal multiply gives exactly here.
    logic [15:0]      s_up;
    logic [31:0]      s_prod;
    logic [IMP_W-1:0] s_tenth;
    assign s_up    = 16'(rdata_reg.si) + 16'd9;
    assign s_prod  = 32'(s_up) * 32'd52429;
    assign s_tenth = IMP_W'(s_prod[31:19]);

    logic spread_ok;
    assign spread_ok = $signed({3'b0, rdata_reg.si}) >= $signed({{2{amt_reg[15]}}, amt_reg});
    assign sts.need_tgt = (op_reg == OP_SPREAD) && is_single && spread_ok;

    // Sweep pointers and accumulators.
    logic [UW-1:0] rp_reg;
    logic          v1_reg;
    logic [AW-1:0] i1_reg;
    logic [31:0]   sum_i_reg, sum_c_reg;
    logic [IMP_W-1:0] best_reg;
    logic [AW-1:0]    bi_reg;
    logic          bfound_reg;

    assign sts.sw_last = (rp_reg + 1'b1 >= used_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.sw_step;
        end
    end

    always_ff @(posedge aclk) begin
        i1_reg <= rp_reg[AW-1:0];
        if (cmd.sw_start) begin
            rp_reg     <= '0;
            sum_i_reg  <= '0;
            sum_c_reg  <= '0;
            best_reg   <= '0;
            bi_reg     <= '0;
            bfound_reg <= 1'b0;
        end else begin
            if (cmd.sw_step) rp_reg <= rp_reg + 1'b1;
            if (v1_reg) begin
                sum_i_reg <= sum_i_reg + rdata_reg.inf;
                sum_c_reg <= sum_c_reg + rdata_reg.cyc;
                if (!bfound_reg || rdata_reg.si > best_reg) begin
                    best_reg   <= rdata_reg.si;
                    bi_reg     <= i1_reg;
                    bfound_reg <= 1'b1;
                end
            end
        end
    end

    // Memory port control and single-entry updates.
    rec_t r;
    always_comb begin
        r         = rdata_reg;
        we        = 1'b0;
        waddr     = e_addr;
        wdata     = rdata_reg;
        re        = cmd.rd_src | cmd.rd_tgt | cmd.sw_step;
        raddr     = cmd.rd_tgt ? t_addr :
                    cmd.sw_step ? rp_reg[AW-1:0] : e_addr;
        used_next = used_reg;
        if (cmd.exec) begin
            case (op_reg)
                OP_ALLOC: begin
                    if (!full) begin
                        we        = 1'b1;
                        waddr     = used_reg[AW-1:0];
                        wdata     = '0;
                        used_next = used_reg + 1'b1;
                    end
                end
                OP_THINK, OP_INFER, OP_LEARN: begin
                    r.md  = op_reg[MODE_W-1:0];
                    r.cyc = rdata_reg.cyc + 1'b1;
                    if (op_reg == OP_INFER) r.inf = rdata_reg.inf + 1'b1;
                    we = is_single; wdata = r;
                end
                OP_UPDATE: begin
                    r.si = clampi(18'($signed({3'b0, rdata_reg.si})) + 18'(ds_reg));
                    r.li = clampi(18'($signed({3'b0, rdata_reg.li})) + 18'(dl_reg));
                    we = is_single; wdata = r;
                end
                OP_SPREAD: begin
                    r.si = clampi(18'($signed({3'b0, rdata_reg.si})) - 18'(amt_reg));
                    we = sts.need_tgt; wdata = r;
                end
                OP_BOOST: begin
                    r.si = clampi(18'($signed({3'b0, rdata_reg.si})) + 18'(amt_reg));
                    r.li = clampi(18'($signed({3'b0, rdata_reg.li})) + amt_div);
                    we = is_single; wdata = r;
                end
                OP_SLEEP: begin
                    r.md = MODE_WAITING;
                    r.si = rdata_reg.si - s_tenth;
                    we = is_single; wdata = r;
                end
                OP_RESUME: begin
                    r.md = MODE_IDLE;
                    we = is_single; wdata = r;
                end
                default: ;
            endcase
        end else if (cmd.exec2) begin
            r.si  = clampi(18'($signed({3'b0, rdata_reg.si})) + 18'(amt_reg));
            we    = 1'b1;
            waddr = t_addr;
            wdata = r;
        end
        // Decay writes each entry back in the cycle after its read is issued.
        if (v1_reg && op_reg == OP_DECAY && !cmd.exec && !cmd.exec2) begin
            r     = rdata_reg;
            if (rdata_reg.si != '0) r.si = rdata_reg.si - 1'b1;
            we    = 1'b1;
            waddr = i1_reg;
            wdata = r;
        end
    end

    // Query result from the entry read.
    logic [15:0] prio;
    logic [15:0] slc;
    always_comb begin
        prio = {1'b0, rdata_reg.si};
        if (rdata_reg.md == MODE_THINKING)       prio = prio + 16'd10;
        else if (rdata_reg.md == MODE_REASONING) prio = prio + 16'd20;
        if (rdata_reg.si > 15'd100)     slc = slice_long;
        else if (rdata_reg.si > 15'd50) slc = slice_mid;
        else                            slc = slice_short;
    end

    // Result registers, loaded at the end of the operation.
    logic [1:0]  st_c;
    logic [5:0]  ix_c;
    logic        fd_c;
    logic [15:0] pr_c, sl_c;
    logic [31:0] ti_c, tc_c;
    logic [6:0]  tt_c;
    logic        qlive_reg;
    logic        alloc_ok_reg;

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            qlive_reg    <= is_single;
            alloc_ok_reg <= !full;
        end
    end

    always_comb begin
        st_c = ST_OK; ix_c = '0; fd_c = 1'b0; pr_c = '0; sl_c = '0;
        ti_c = '0; tc_c = '0; tt_c = '0;
        case (op_reg)
            OP_ALLOC: begin
                if (!alloc_ok_reg) st_c = ST_FULL;
                else ix_c = 6'(32'(used_reg) - 1);
            end
            OP_THINK, OP_INFER, OP_LEARN, OP_UPDATE, OP_BOOST, OP_SLEEP,
            OP_RESUME, OP_SPREAD: if (!qlive_reg) st_c = ST_BAD;
            OP_STATS: begin
                ti_c = sum_i_reg; tc_c = sum_c_reg; tt_c = 7'(used_reg);
            end
            OP_FINDMAX: begin
                fd_c = bfound_reg && !sts.sw_empty;
                if (fd_c) ix_c = 6'(bi_reg);
            end
            OP_QUERY: begin
                if (qlive_reg) begin pr_c = prio; sl_c = slc; end
                else sl_c = slice_mid;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_status <= st_c; o_index <= ix_c; o_found <= fd_c; o_prio <= pr_c;
            o_slice <= sl_c; o_tinf <= ti_c; o_tcyc <= tc_c; o_total <= tt_c;
        end
    end

    `ASSERT_CLK(a_used_bound, aclk, aresetn, used_reg <= DEPTH_U,
        "entry count exceeds table depth")
    `ASSERT_CLK(a_one_cmd, aclk, aresetn,
        $countones({cmd.exec, cmd.exec2, cmd.sw_step, cmd.out_load}) <= 1,
        "conflicting datapath commands")
    `ASSERT_CLK(a_used_step, aclk, aresetn,
        used_reg == $past(used_reg) || used_reg == $past(used_reg) + 1'b1,
        "entry count moved by more than one")
endmodule
`default_nettype wire
